@@ sv/dsfe_pkg.sv @@
// Shared types, constants and the frame builder of the DShot frame symbol encoder.
package dsfe_pkg;

    localparam int MotorsDefault = 4;
    localparam int FrameBits     = 16;
    localparam int QueueDepth    = 2;

    localparam int MotorW    = 2;
    localparam int ThrInW    = 16;
    localparam int ThrW      = 11;
    localparam int TickW     = 8;
    localparam int EnW       = 4;
    localparam int BitIdxW   = 4;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 11;
    localparam int InDataW   = 24;
    localparam int OutDataW  = 40;

    localparam logic [ThrW-1:0]  ThrMinRst   = 11'd48;
    localparam logic [ThrW-1:0]  ThrMaxRst   = 11'd2047;
    localparam logic [TickW-1:0] OneHighRst  = 8'd50;
    localparam logic [TickW-1:0] OneLowRst   = 8'd17;
    localparam logic [TickW-1:0] ZeroHighRst = 8'd25;
    localparam logic [TickW-1:0] ZeroLowRst  = 8'd42;
    localparam logic [EnW-1:0]   ChanEnRst   = 4'hF;

    typedef enum logic [CfgIdxW-1:0] {
        REG_THROTTLE_MIN    = 3'd0,
        REG_THROTTLE_MAX    = 3'd1,
        REG_ONE_HIGH_TICKS  = 3'd2,
        REG_ONE_LOW_TICKS   = 3'd3,
        REG_ZERO_HIGH_TICKS = 3'd4,
        REG_ZERO_LOW_TICKS  = 3'd5,
        REG_CHANNEL_ENABLE  = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [ThrW-1:0] thr_min;
        logic [ThrW-1:0] thr_max;
        logic [EnW-1:0]  chan_en;
    } front_cfg_t;

    typedef struct packed {
        logic [TickW-1:0] one_high;
        logic [TickW-1:0] one_low;
        logic [TickW-1:0] zero_high;
        logic [TickW-1:0] zero_low;
    } tick_cfg_t;

    typedef struct packed {
        logic [MotorW-1:0]    motor;
        logic [FrameBits-1:0] frame;
    } frame_entry_t;

    // 11-bit throttle, telemetry bit, then the nibble-XOR checksum
    function automatic logic [FrameBits-1:0] dshot_frame(
        input logic [ThrW-1:0] thr,
        input logic            tele
    );
        logic [11:0] value;
        logic [3:0]  csum;
        value = {thr, tele};
        csum  = value[3:0] ^ value[7:4] ^ value[11:8];
        return {value, csum};
    endfunction

endpackage

@@ sv/dsfe_front.sv @@
// Request front end: channel check, throttle clamp and frame build.
module dsfe_front
    import dsfe_pkg::*;
#(
    parameter int MOTORS = MotorsDefault
) (
    input  logic                      req_valid,
    output logic                      req_ready,
    input  logic [MotorW-1:0]         motor,
    input  logic [ThrInW-1:0]         throttle,
    input  logic                      request_telemetry,
    input  front_cfg_t                cfg,
    input  logic                      q_full,
    output logic                      q_push,
    output frame_entry_t              q_entry
);

    logic            chan_ok;
    logic [ThrW-1:0] thr_hi;
    logic [ThrW-1:0] thr_clamped;

    always_comb
    begin
        chan_ok = (32'(motor) < MOTORS) && cfg.chan_en[motor];
        // upper clamp first, then lower, so the minimum wins a conflict
        if (throttle > {{(ThrInW-ThrW){1'b0}}, cfg.thr_max})
            thr_hi = cfg.thr_max;
        else
            thr_hi = throttle[ThrW-1:0];
        if (thr_hi < cfg.thr_min)
            thr_clamped = cfg.thr_min;
        else
            thr_clamped = thr_hi;
    end

    // drop requests for absent or disabled channels without touching the queue
    assign req_ready     = !q_full;
    assign q_push        = req_valid && !q_full && chan_ok;
    assign q_entry.motor = motor;
    assign q_entry.frame = dshot_frame(thr_clamped, request_telemetry);

endmodule

@@ sv/dsfe_queue.sv @@
// Short frame queue between the request front end and the symbol back end.
module dsfe_queue
    import dsfe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  frame_entry_t push_entry,
    output logic         full,
    input  logic         pop,
    output logic         not_empty,
    output frame_entry_t head
);

    localparam int PtrW = $clog2(QueueDepth);
    localparam int CntW = $clog2(QueueDepth + 1);

    frame_entry_t mem [QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full      = (count_reg == CntW'(QueueDepth));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

endmodule

@@ sv/dsfe_back.sv @@
// Symbol back end: splits a queued frame into 16 pulse symbols, MSB first.
module dsfe_back
    import dsfe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_not_empty,
    input  frame_entry_t          q_head,
    output logic                  q_pop,
    input  tick_cfg_t             ticks,
    output logic                  sym_valid,
    input  logic                  sym_ready,
    output logic [MotorW-1:0]     channel,
    output logic [BitIdxW-1:0]    bit_index,
    output logic                  bit_value,
    output logic [TickW-1:0]      high_ticks,
    output logic [TickW-1:0]      low_ticks,
    output logic [FrameBits-1:0]  frame_word,
    output logic                  last
);

    localparam logic [BitIdxW-1:0] LastIdx = BitIdxW'(FrameBits - 1);

    logic                 busy_reg, busy_next;
    logic [BitIdxW-1:0]   idx_reg, idx_next;
    frame_entry_t         cur_reg, cur_next;
    logic                 out_valid_reg, out_valid_next;
    logic [MotorW-1:0]    chan_reg, chan_next;
    logic [BitIdxW-1:0]   bidx_reg, bidx_next;
    logic                 bval_reg, bval_next;
    logic [TickW-1:0]     hi_reg, hi_next;
    logic [TickW-1:0]     lo_reg, lo_next;
    logic [FrameBits-1:0] word_reg, word_next;
    logic                 last_reg, last_next;

    logic                 advance;
    frame_entry_t         src;
    logic [BitIdxW-1:0]   src_idx;
    logic                 src_bit;

    always_comb
    begin
        advance = !out_valid_reg || sym_ready;
        src     = busy_reg ? cur_reg : q_head;
        src_idx = busy_reg ? idx_reg : '0;
        src_bit = src.frame[LastIdx - src_idx];
        q_pop   = advance && !busy_reg && q_not_empty;

        busy_next      = busy_reg;
        idx_next       = idx_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        chan_next      = chan_reg;
        bidx_next      = bidx_reg;
        bval_next      = bval_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        word_next      = word_reg;
        last_next      = last_reg;

        if (advance)
        begin
            if (busy_reg || q_not_empty)
            begin
                // emit one symbol per beat; pick up a new frame as the old one ends
                out_valid_next = 1'b1;
                chan_next      = src.motor;
                bidx_next      = src_idx;
                bval_next      = src_bit;
                hi_next        = src_bit ? ticks.one_high : ticks.zero_high;
                lo_next        = src_bit ? ticks.one_low  : ticks.zero_low;
                word_next      = src.frame;
                last_next      = (src_idx == LastIdx);
                cur_next       = src;
                idx_next       = src_idx + 1'b1;
                busy_next      = (src_idx != LastIdx);
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        chan_reg <= chan_next;
        bidx_reg <= bidx_next;
        bval_reg <= bval_next;
        hi_reg   <= hi_next;
        lo_reg   <= lo_next;
        word_reg <= word_next;
        last_reg <= last_next;
    end

    assign sym_valid  = out_valid_reg;
    assign channel    = chan_reg;
    assign bit_index  = bidx_reg;
    assign bit_value  = bval_reg;
    assign high_ticks = hi_reg;
    assign low_ticks  = lo_reg;
    assign frame_word = word_reg;
    assign last       = last_reg;

endmodule

@@ sv/dshot_frame_symbol_encoder_core.sv @@
// DShot frame symbol encoder top level: registers, front end, queue and back end.
//
// Requests arrive on the s_ stream (motor, raw throttle, telemetry bit). A request
// for an enabled motor is clamped to throttle_max then throttle_min, packed into
// a 16-bit DShot frame with nibble-XOR checksum and queued; a request for a
// disabled or absent motor is taken and dropped. The m_ stream then carries the
// frame as 16 pulse symbols, MSB first, one per beat, with the high and low tick
// counts of a one or a zero bit; m_tlast marks the sixteenth symbol.
// Path: a request is written into the frame queue and, when the back end is
// free, its first symbol into the back end's output register. Throughput: one
// symbol per cycle while m_tready stays high. A two-entry frame queue takes up to
// two more requests while a frame is being sent; past that s_tready follows the
// back end, taking one request as each frame leaves the queue. Reset clears the
// queue and output valid and loads the default register values. When the
// receiver holds m_tready low the current symbol holds, the back end stops, and
// s_tready falls once the queue is full. Configuration is written through
// cfg_we/cfg_index/cfg_data; the user must do so only while idle (not enforced).
module dshot_frame_symbol_encoder_core
    import dsfe_pkg::*;
#(
    parameter int MOTORS = MotorsDefault
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [InDataW-1:0]    s_tdata,   // motor, throttle, request_telemetry, pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OutDataW-1:0]   m_tdata,   // channel, bit_index, bit_value, high_ticks,
                                             // low_ticks, frame_word, pad
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CfgIdxW-1:0]    cfg_index,
    input  logic [CfgDataW-1:0]   cfg_data
);

    logic [ThrW-1:0]  thr_min_reg;
    logic [ThrW-1:0]  thr_max_reg;
    logic [TickW-1:0] one_high_reg;
    logic [TickW-1:0] one_low_reg;
    logic [TickW-1:0] zero_high_reg;
    logic [TickW-1:0] zero_low_reg;
    logic [EnW-1:0]   chan_en_reg;

    front_cfg_t   front_cfg;
    tick_cfg_t    tick_cfg;
    logic         q_full;
    logic         q_push;
    logic         q_pop;
    logic         q_not_empty;
    frame_entry_t q_in;
    frame_entry_t q_head;

    logic [MotorW-1:0]    channel;
    logic [BitIdxW-1:0]   bit_index;
    logic                 bit_value;
    logic [TickW-1:0]     high_ticks;
    logic [TickW-1:0]     low_ticks;
    logic [FrameBits-1:0] frame_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_min_reg   <= ThrMinRst;
            thr_max_reg   <= ThrMaxRst;
            one_high_reg  <= OneHighRst;
            one_low_reg   <= OneLowRst;
            zero_high_reg <= ZeroHighRst;
            zero_low_reg  <= ZeroLowRst;
            chan_en_reg   <= ChanEnRst;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_THROTTLE_MIN:    thr_min_reg   <= cfg_data[ThrW-1:0];
                REG_THROTTLE_MAX:    thr_max_reg   <= cfg_data[ThrW-1:0];
                REG_ONE_HIGH_TICKS:  one_high_reg  <= cfg_data[TickW-1:0];
                REG_ONE_LOW_TICKS:   one_low_reg   <= cfg_data[TickW-1:0];
                REG_ZERO_HIGH_TICKS: zero_high_reg <= cfg_data[TickW-1:0];
                REG_ZERO_LOW_TICKS:  zero_low_reg  <= cfg_data[TickW-1:0];
                REG_CHANNEL_ENABLE:  chan_en_reg   <= cfg_data[EnW-1:0];
                default: ;
            endcase
        end
    end

    assign front_cfg.thr_min = thr_min_reg;
    assign front_cfg.thr_max = thr_max_reg;
    assign front_cfg.chan_en = chan_en_reg;
    assign tick_cfg.one_high  = one_high_reg;
    assign tick_cfg.one_low   = one_low_reg;
    assign tick_cfg.zero_high = zero_high_reg;
    assign tick_cfg.zero_low  = zero_low_reg;

    dsfe_front #(
        .MOTORS (MOTORS)
    ) u_front (
        .req_valid         (s_tvalid),
        .req_ready         (s_tready),
        .motor             (s_tdata[1:0]),
        .throttle          (s_tdata[17:2]),
        .request_telemetry (s_tdata[18]),
        .cfg               (front_cfg),
        .q_full            (q_full),
        .q_push            (q_push),
        .q_entry           (q_in)
    );

    dsfe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    dsfe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .ticks       (tick_cfg),
        .sym_valid   (m_tvalid),
        .sym_ready   (m_tready),
        .channel     (channel),
        .bit_index   (bit_index),
        .bit_value   (bit_value),
        .high_ticks  (high_ticks),
        .low_ticks   (low_ticks),
        .frame_word  (frame_word),
        .last        (m_tlast)
    );

    assign m_tdata = {1'b0, frame_word, low_ticks, high_ticks, bit_value, bit_index, channel};

endmodule
